### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL; both sample on clk and hold off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/core/aed_pkg.sv
package aed_pkg;

	localparam int TIME_W   = 32;
	localparam int PAUSE_W  = 16;
	localparam int PCT_W    = 7;
	localparam int MOTION_W = 16;
	localparam int RECENT_W = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PAUSE_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DROP_LIMIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STILL_LIMIT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW      = 2'd3;

	// register reset values
	localparam logic [PAUSE_W-1:0]  PAUSE_LIMIT_RST = 16'd15000;
	localparam logic [PCT_W-1:0]    DROP_LIMIT_RST  = 7'd3;
	localparam logic [MOTION_W-1:0] STILL_LIMIT_RST = 16'd154;
	localparam logic [TIME_W-1:0]   WINDOW_RST      = 32'd3600000;

	localparam logic [PAUSE_W-1:0]  PAUSE_SAT  = 16'hFFFF;
	localparam logic [RECENT_W-1:0] RECENT_SAT = 5'd31;

	// control from the sequencer to the age counter
	typedef struct packed {
		logic clr;   // start a new count
		logic step;  // tail cell is presented this cycle
	} count_ctl_t;

endpackage

### rtl/core/apnea_event_detector.sv
// An accepted word passes through S_EVAL, S_COUNT and S_DONE, and its result word is then
//   loaded into the output register; the next word is taken only after that load. The onset
//   chain rotates once per word past a single age comparator, one cell per cycle.
// Reset (arst_n low, asynchronous): registers return to their defaults, onset chain empties,
//   arming and SpO2 calibration restart. No clearing pass; the block takes a word right away.
`include "assert_macros.svh"

module apnea_event_detector
	import aed_pkg::*;
#(
	parameter int EVENT_SLOTS    = 20,
	parameter int CALIB_READINGS = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [31:0] time_ms, [32] breath_seen, [33] oxygen_valid, [40:34] oxygen_pct,
	// [56:41] motion_mag, [63:57] zero
	input  logic [63:0]           s_tdata,
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [0] apnea_active, [16:1] pause_len_ms, [21:17] recent_events, [23:22] zero
	output logic [23:0]           m_tdata,
	// configuration writes
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CAL_W = $clog2(CALIB_READINGS + 1);
	localparam int IDX_W = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;

	// sequencer codes
	localparam logic [1:0] S_IDLE  = 2'd0;  // wait for a word
	localparam logic [1:0] S_EVAL  = 2'd1;  // scalar checks, insert onset
	localparam logic [1:0] S_COUNT = 2'd2;  // rotate chain past the comparator
	localparam logic [1:0] S_DONE  = 2'd3;  // hand result to output register

	// ---------------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------------
	logic [PAUSE_W-1:0]  pause_limit_q;
	logic [PCT_W-1:0]    drop_limit_q;
	logic [MOTION_W-1:0] still_limit_q;
	logic [TIME_W-1:0]   window_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pause_limit_q <= PAUSE_LIMIT_RST;
			drop_limit_q  <= DROP_LIMIT_RST;
			still_limit_q <= STILL_LIMIT_RST;
			window_q      <= WINDOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PAUSE_LIMIT: pause_limit_q <= cfg_data[PAUSE_W-1:0];
				REG_DROP_LIMIT:  drop_limit_q  <= cfg_data[PCT_W-1:0];
				REG_STILL_LIMIT: still_limit_q <= cfg_data[MOTION_W-1:0];
				REG_WINDOW:      window_q      <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Sequencer and held input word
	// ---------------------------------------------------------------------
	logic [1:0]          state_q;
	logic [IDX_W-1:0]    step_q;
	logic [TIME_W-1:0]   now_q;
	logic                breath_q;
	logic                ox_valid_q;
	logic [PCT_W-1:0]    ox_q;
	logic [MOTION_W-1:0] motion_q;
	logic                in_fire;
	logic                out_load;
	logic                last_step;

	assign s_tready  = (state_q == S_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign last_step = (step_q == IDX_W'(EVENT_SLOTS - 1));

	// Latch the word; the fields hold until the next accept.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			now_q      <= s_tdata[31:0];
			breath_q   <= s_tdata[32];
			ox_valid_q <= s_tdata[33];
			ox_q       <= s_tdata[40:34];
			motion_q   <= s_tdata[56:41];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) state_q <= S_EVAL;
				end
				S_EVAL: begin
					step_q  <= '0;
					state_q <= S_COUNT;
				end
				S_COUNT: begin
					step_q <= step_q + IDX_W'(1);
					if (last_step) state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Per-word scalar logic (evaluated in S_EVAL)
	// ---------------------------------------------------------------------
	logic                armed_q;
	logic [TIME_W-1:0]   last_breath_q;
	logic [PCT_W-1:0]    baseline_q;
	logic [CAL_W-1:0]    calib_seen_q;
	logic                baseline_ready_q;
	logic                apnea_prev_q;

	logic [TIME_W-1:0]   last_breath_d;
	logic [TIME_W-1:0]   gap;
	logic [PAUSE_W-1:0]  pause;
	logic                calib_take;
	logic [CAL_W-1:0]    calib_seen_d;
	logic                baseline_ready_d;
	logic [PCT_W-1:0]    baseline_d;
	logic [PCT_W:0]      ox_plus_drop;
	logic                pause_hit;
	logic                desat;
	logic                still;
	logic                apnea;
	logic                onset;
	logic                eval;

	assign eval = (state_q == S_EVAL);

	// The first word after reset arms the pause timer at its own time.
	assign last_breath_d = (!armed_q || breath_q) ? now_q : last_breath_q;
	assign gap           = now_q - last_breath_d;
	assign pause         = (|gap[TIME_W-1:PAUSE_W]) ? PAUSE_SAT : gap[PAUSE_W-1:0];

	// Each valid reading during calibration replaces the baseline; freeze at the last.
	assign calib_take       = !baseline_ready_q && ox_valid_q &&
	                          (calib_seen_q < CAL_W'(CALIB_READINGS));
	assign calib_seen_d     = calib_take ? calib_seen_q + CAL_W'(1) : calib_seen_q;
	assign baseline_ready_d = baseline_ready_q ||
	                          (calib_seen_d >= CAL_W'(CALIB_READINGS));
	assign baseline_d       = calib_take ? ox_q : baseline_q;

	// baseline - ox >= drop, signed, rewritten as baseline >= ox + drop
	assign ox_plus_drop = {1'b0, ox_q} + {1'b0, drop_limit_q};
	assign pause_hit    = (pause >= pause_limit_q);
	assign desat        = baseline_ready_d && ox_valid_q &&
	                      ({1'b0, baseline_d} >= ox_plus_drop);
	assign still        = (motion_q < still_limit_q);
	assign apnea        = pause_hit && still && (desat || !ox_valid_q);
	assign onset        = apnea && !apnea_prev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q          <= 1'b0;
			last_breath_q    <= '0;
			baseline_q       <= '0;
			calib_seen_q     <= '0;
			baseline_ready_q <= 1'b0;
			apnea_prev_q     <= 1'b0;
		end else if (eval) begin
			armed_q          <= 1'b1;
			last_breath_q    <= last_breath_d;
			baseline_q       <= baseline_d;
			calib_seen_q     <= calib_seen_d;
			baseline_ready_q <= baseline_ready_d;
			apnea_prev_q     <= apnea;
		end
	end

	// hold this word's scalar results until the count finishes
	logic               apnea_q;
	logic [PAUSE_W-1:0] pause_q;

	always_ff @(posedge clk) begin
		if (eval) begin
			apnea_q <= apnea;
			pause_q <= pause;
		end
	end

	// ---------------------------------------------------------------------
	// Onset chain: cell 0 takes the newest onset, the last cell drops the
	// oldest. While counting, the tail wraps back to cell 0 so that after
	// EVENT_SLOTS shifts every cell is back in place.
	// ---------------------------------------------------------------------
	logic [TIME_W-1:0]      cell_time  [EVENT_SLOTS];
	logic [EVENT_SLOTS-1:0] cell_valid;
	logic                   chain_shift;
	logic [TIME_W-1:0]      head_time;
	logic                   head_valid;
	logic                   counting;

	assign counting    = (state_q == S_COUNT);
	assign chain_shift = (eval && onset) || counting;
	assign head_time   = counting ? cell_time[EVENT_SLOTS-1] : now_q;
	assign head_valid  = counting ? cell_valid[EVENT_SLOTS-1] : 1'b1;

	for (genvar g = 0; g < EVENT_SLOTS; g++) begin : g_cell
		if (g == 0) begin : g_head
			aed_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift   (chain_shift),
				.d_time  (head_time),
				.d_valid (head_valid),
				.q_time  (cell_time[g]),
				.q_valid (cell_valid[g])
			);
		end else begin : g_body
			aed_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift   (chain_shift),
				.d_time  (cell_time[g-1]),
				.d_valid (cell_valid[g-1]),
				.q_time  (cell_time[g]),
				.q_valid (cell_valid[g])
			);
		end
	end

	// ---------------------------------------------------------------------
	// Age counter at the tail of the chain
	// ---------------------------------------------------------------------
	count_ctl_t          cnt_ctl;
	logic [RECENT_W-1:0] recent;

	assign cnt_ctl.clr  = eval;
	assign cnt_ctl.step = counting;

	aed_count #(
		.EVENT_SLOTS (EVENT_SLOTS)
	) u_count (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (cnt_ctl),
		.now        (now_q),
		.window     (window_q),
		.tail_time  (cell_time[EVENT_SLOTS-1]),
		.tail_valid (cell_valid[EVENT_SLOTS-1]),
		.count      (recent)
	);

	// ---------------------------------------------------------------------
	// Output register: a finished word waits here while the next one is taken.
	// ---------------------------------------------------------------------
	logic        m_tvalid_q;
	logic [23:0] m_tdata_q;

	assign out_load = (state_q == S_DONE) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {2'b00, recent, pause_q, apnea_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	// a result word appears only out of the hand-off state
	`ASSERT_NEXT(a_load_from_done, !m_tvalid_q && !out_load, !$rose(m_tvalid_q))
	// the reported count never exceeds the onsets held in the chain
	`ASSERT_NEXT(a_count_bound, out_load,
		int'(m_tdata_q[21:17]) <= $countones(cell_valid))
	// apnea is reported only with a long pause
	`ASSERT_SAME(a_apnea_pause, m_tvalid_q && m_tdata_q[0],
		m_tdata_q[16:1] >= pause_limit_q)
	// the chain only moves while an onset is inserted or the count runs
	`ASSERT_SAME(a_chain_quiet, state_q == S_IDLE || state_q == S_DONE, !chain_shift)

endmodule

### rtl/core/aed_cell.sv
module aed_cell
	import aed_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift,
	input  logic [TIME_W-1:0] d_time,
	input  logic              d_valid,
	output logic [TIME_W-1:0] q_time,
	output logic              q_valid
);

	logic [TIME_W-1:0] time_q;
	logic              valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			time_q <= d_time;
		end
	end

	assign q_time  = time_q;
	assign q_valid = valid_q;

endmodule

### rtl/core/aed_count.sv
module aed_count
	import aed_pkg::*;
#(
	parameter int EVENT_SLOTS = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  count_ctl_t          ctl,
	input  logic [TIME_W-1:0]   now,
	input  logic [TIME_W-1:0]   window,
	input  logic [TIME_W-1:0]   tail_time,
	input  logic                tail_valid,
	output logic [RECENT_W-1:0] count
);

	localparam int SLOT_CW = $clog2(EVENT_SLOTS + 1);
	localparam int ACC_W   = (SLOT_CW > RECENT_W) ? SLOT_CW : RECENT_W;

	logic [ACC_W-1:0]  acc_q;
	logic [TIME_W-1:0] age;
	logic              hit;

	// wrapping age of the presented onset
	assign age = now - tail_time;
	assign hit = tail_valid && (age < window);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.step && hit) begin
			acc_q <= acc_q + ACC_W'(1);
		end
	end

	assign count = (acc_q > ACC_W'(RECENT_SAT)) ? RECENT_SAT : acc_q[RECENT_W-1:0];

endmodule
